// ===== rtl/prc_pkg.sv =====
// shared constants, types and codes of the pairwise row correlation block
`timescale 1ns / 1ps

package prc_pkg;

    localparam int DATA_W        = 32;
    localparam int DEV_W         = 33;
    localparam int SD_W          = 26;
    localparam int DEV_LIMIT_BIT = 25;
    localparam int SH_W          = 4;
    localparam int SH_MAX        = 8;
    localparam int ACC_W         = 64;
    localparam int PROD_W        = 2 * SD_W;
    localparam int COEF_W        = 16;
    localparam int ROW_PORT_W    = 3;
    localparam int CFG_ROWS_W    = 4;
    localparam int CFG_COLS_W    = 9;
    localparam int CFG_DATA_W    = 9;
    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_MAX_COLS  = 256;
    localparam int ROWS_RESET    = 8;
    localparam int COLS_RESET    = 256;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_SUM  = 2'd1,
        OP_MAX  = 2'd2,
        OP_PAIR = 2'd3
    } t_op;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_token;

    typedef struct packed {
        logic clear;
        logic div_start;
    } t_cell_ctl;

endpackage

// ===== rtl/prc_row_cell.sv =====
// one row cell: sample memory, row sum, mean divider, peak deviation and shift
`timescale 1ns / 1ps

module prc_row_cell #(
    parameter int MAX_COLS = prc_pkg::DEF_MAX_COLS,
    parameter int ROW_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  prc_pkg::t_token                   i_tok,
    input  logic [$clog2(MAX_COLS)-1:0]       i_col,
    output prc_pkg::t_token                   o_tok,
    output logic [$clog2(MAX_COLS)-1:0]       o_col,
    output logic [prc_pkg::DATA_W-1:0]        o_data,
    input  prc_pkg::t_cell_ctl                i_ctl,
    input  logic [$clog2(MAX_COLS+1)-1:0]     i_n,
    input  logic                              i_we,
    input  logic [ROW_W-1:0]                  i_wrow,
    input  logic [$clog2(MAX_COLS)-1:0]       i_wcol,
    input  logic [prc_pkg::DATA_W-1:0]        i_wdata,
    output logic [prc_pkg::DATA_W-1:0]        o_mean,
    output logic [prc_pkg::SH_W-1:0]          o_shift
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int N_W    = $clog2(MAX_COLS + 1);
    localparam int SUM_W  = prc_pkg::DATA_W + COL_W + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int DW     = prc_pkg::DATA_W;
    localparam int VW     = prc_pkg::DEV_W;

    logic [DW-1:0]     r_mem [MAX_COLS];
    logic [DW-1:0]     r_data;
    prc_pkg::t_token   r_tok;
    logic [COL_W-1:0]  r_col;
    logic signed [SUM_W-1:0] r_sum;
    logic [VW-1:0]     r_max;
    logic [SUM_W-1:0]  r_dvd;
    logic [N_W-1:0]    r_rem;
    logic              r_neg;
    logic [DCNT_W-1:0] r_dcnt;

    logic [N_W:0]      w_rem2;
    logic              w_ge;
    logic [DW-1:0]     w_mean;
    logic signed [VW-1:0] w_dev;
    logic [VW-1:0]     w_abs;
    logic [prc_pkg::SH_W-1:0] w_shift;

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_we && (i_wrow == ROW_W'(CELL_IDX))) begin
            r_mem[i_wcol] <= i_wdata;
        end
        r_data <= r_mem[i_col];
        r_col  <= i_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '{vld: 1'b0, op: prc_pkg::OP_IDLE};
        end else begin
            r_tok <= i_tok;
        end
    end

    assign w_mean = r_neg ? DW'(-r_dvd[DW-1:0]) : r_dvd[DW-1:0];
    assign w_dev  = $signed({r_data[DW-1], r_data}) - $signed({w_mean[DW-1], w_mean});
    assign w_abs  = w_dev[VW-1] ? VW'(-w_dev) : VW'(w_dev);

    // row sum and peak deviation
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
            r_max <= '0;
        end else if (r_tok.vld && (r_tok.op == prc_pkg::OP_SUM)) begin
            r_sum <= r_sum + $signed({{(SUM_W-DW){r_data[DW-1]}}, r_data});
        end else if (r_tok.vld && (r_tok.op == prc_pkg::OP_MAX)) begin
            if (w_abs > r_max) begin
                r_max <= w_abs;
            end
        end
    end

    // restoring divider for the mean, one quotient bit a cycle
    assign w_rem2 = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, i_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_ctl.div_start) begin
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_neg <= r_sum[SUM_W-1];
            r_dvd <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem <= '0;
        end else if (r_dcnt != '0) begin
            r_rem <= w_ge ? N_W'(w_rem2 - {1'b0, i_n}) : w_rem2[N_W-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
        end
    end

    // smallest shift that brings the peak deviation under the limit
    always_comb begin
        w_shift = '0;
        for (int i = 0; i < prc_pkg::SH_MAX; i++) begin
            if (r_max[prc_pkg::DEV_LIMIT_BIT + i]) begin
                w_shift = prc_pkg::SH_W'(i + 1);
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_col   = r_col;
    assign o_data  = r_data;
    assign o_mean  = w_mean;
    assign o_shift = w_shift;

endmodule

// ===== rtl/prc_corr_unit.sv =====
// wide product, integer square root and quotient that turn pair sums into a coefficient
`timescale 1ns / 1ps

module prc_corr_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [prc_pkg::ACC_W-1:0]         i_sxx,
    input  logic [prc_pkg::ACC_W-1:0]         i_syy,
    input  logic signed [prc_pkg::ACC_W-1:0]  i_sxy,
    output logic                              o_done,
    output logic signed [prc_pkg::COEF_W-1:0] o_coef,
    output logic                              o_degenerate
);

    localparam int AW  = prc_pkg::ACC_W;
    localparam int RW  = 2 * AW;
    localparam int HW  = AW / 2;
    localparam int SRW = AW + 4;
    localparam int QW  = prc_pkg::COEF_W + 1;
    localparam int CW  = prc_pkg::COEF_W;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_MUL  = 5'b00010,
        C_SQRT = 5'b00100,
        C_DIV  = 5'b01000,
        C_FIN  = 5'b10000
    } t_cstate;

    t_cstate          r_state;
    logic [AW-1:0]    r_a;
    logic [AW-1:0]    r_b;
    logic [AW-1:0]    r_mag;
    logic             r_neg;
    logic             r_deg;
    logic [2:0]       r_k;
    logic [AW-1:0]    r_pp;
    logic [1:0]       r_psh;
    logic             r_ppv;
    logic [RW-1:0]    r_rad;
    logic [SRW-1:0]   r_rem;
    logic [AW-1:0]    r_root;
    logic [6:0]       r_i;
    logic [AW-1:0]    r_drem;
    logic [QW-1:0]    r_q;
    logic             r_done;
    logic signed [CW-1:0] r_coef;

    logic [HW-1:0]    w_opa;
    logic [HW-1:0]    w_opb;
    logic [AW-1:0]    w_prod;
    logic [RW-1:0]    w_ppx;
    logic [SRW-1:0]   w_rem2;
    logic [SRW-1:0]   w_trial;
    logic [AW:0]      w_drem2;
    logic [QW:0]      w_qr;

    assign w_opa   = r_k[0] ? r_a[AW-1:HW] : r_a[HW-1:0];
    assign w_opb   = r_k[1] ? r_b[AW-1:HW] : r_b[HW-1:0];
    assign w_prod  = w_opa * w_opb;
    assign w_rem2  = {r_rem[SRW-3:0], r_rad[RW-1:RW-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_drem2 = {r_drem, 1'b0};
    assign w_qr    = ({1'b0, r_q} + 1'b1) >> 1;

    always_comb begin
        unique case (r_psh)
            2'd0:    w_ppx = {{AW{1'b0}}, r_pp};
            2'd1:    w_ppx = {{HW{1'b0}}, r_pp, {HW{1'b0}}};
            default: w_ppx = {r_pp, {AW{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_ppv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if ((i_sxx == '0) || (i_syy == '0)) begin
                            r_deg   <= 1'b1;
                            r_state <= C_FIN;
                        end else begin
                            r_deg   <= 1'b0;
                            r_state <= C_MUL;
                        end
                        r_a   <= i_sxx;
                        r_b   <= i_syy;
                        r_neg <= i_sxy[AW-1];
                        r_mag <= i_sxy[AW-1] ? AW'(-i_sxy) : AW'(i_sxy);
                        r_k   <= '0;
                        r_ppv <= 1'b0;
                        r_rad <= '0;
                    end
                end
                // four 32x32 partial products, each registered before the add
                C_MUL: begin
                    if (r_k != 3'd4) begin
                        r_pp  <= w_prod;
                        r_psh <= 2'(r_k[0]) + 2'(r_k[1]);
                        r_ppv <= 1'b1;
                        r_k   <= r_k + 1'b1;
                    end else begin
                        r_ppv   <= 1'b0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_i     <= '0;
                        r_state <= C_SQRT;
                    end
                    if (r_ppv) begin
                        r_rad <= r_rad + w_ppx;
                    end
                end
                // two radicand bits a step
                C_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= w_rem2 - w_trial;
                        r_root <= {r_root[AW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2;
                        r_root <= {r_root[AW-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[RW-3:0], 2'b00};
                    r_i   <= r_i + 1'b1;
                    if (r_i == 7'(AW - 1)) begin
                        r_state <= C_DIV;
                    end
                    r_drem <= r_mag;
                    r_q    <= '0;
                end
                C_DIV: begin
                    if (r_mag >= r_root) begin
                        r_q     <= QW'(1) << (QW - 1);
                        r_state <= C_FIN;
                    end else begin
                        if (w_drem2 >= {1'b0, r_root}) begin
                            r_drem <= AW'(w_drem2 - {1'b0, r_root});
                            r_q    <= {r_q[QW-2:0], 1'b1};
                        end else begin
                            r_drem <= w_drem2[AW-1:0];
                            r_q    <= {r_q[QW-2:0], 1'b0};
                        end
                        r_mag <= '0;
                        r_i   <= r_i + 1'b1;
                        if (r_i == 7'(AW + QW - 2)) begin
                            r_state <= C_FIN;
                        end
                    end
                end
                C_FIN: begin
                    if (r_deg) begin
                        r_coef <= '0;
                    end else if (!r_neg) begin
                        r_coef <= w_qr[CW-1] ? {1'b0, {(CW-1){1'b1}}} : $signed(w_qr[CW-1:0]);
                    end else begin
                        r_coef <= -$signed(w_qr[CW-1:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_coef       = r_coef;
    assign o_degenerate = r_deg;

endmodule

// ===== rtl/pairwise_row_correlation.sv =====
// top level: loading, chain of row cells, pair accumulation and result output
`timescale 1ns / 1ps

// usage
//   load: the matrix arrives row-major, one sample per item. an item is taken at
//   a clock edge with i_start high and o_busy low, so loading runs at one item a cycle.
//   the item with i_matrix_last set is stored and then starts the run; o_busy is high
//   until the last pair has been sent.
//   results: one item per row pair a<b, ordered by a then b, shown for one cycle with
//   o_strobe; the receiver cannot stall, so nothing is held back. o_last_pair marks the
//   final pair.
//   after the last sample, with R rows in use: a sum sweep, a mean divide over
//     SUM_W = 33+log2 MAX_COLS quotient bits, a peak sweep, then per pair a sweep
//     plus product, square root and quotient; R*(R-1)/2 pairs.
//   pairs run one at a time, sweep then coefficient: one column a cycle through the
//   cell chain, one shared multiply-accumulate path and one shared square root unit.
//   configuration: i_cfg_we writes register i_cfg_index (rows, then columns); the user
//   must write it only while idle, which the block does not enforce.
//   reset: synchronous, active low; load position returns to row 0, column 0, the
//   registers return to 8 rows and 256 columns; sample memory is not cleared.
module pairwise_row_correlation #(
    parameter int MAX_ROWS = prc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = prc_pkg::DEF_MAX_COLS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [prc_pkg::DATA_W-1:0]     i_sample_value,
    input  logic                                  i_matrix_last,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_strobe,
    output logic [prc_pkg::ROW_PORT_W-1:0]        o_first_row,
    output logic [prc_pkg::ROW_PORT_W-1:0]        o_second_row,
    output logic signed [prc_pkg::COEF_W-1:0]     o_coefficient,
    output logic                                  o_degenerate,
    output logic                                  o_last_pair
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int N_W    = $clog2(MAX_COLS + 1);
    localparam int SUM_W  = prc_pkg::DATA_W + COL_W + 1;
    localparam int DRAIN  = MAX_ROWS + 6;
    localparam int CNT_W  = $clog2(MAX_COLS + SUM_W + DRAIN + 8);
    localparam int XD_N   = MAX_ROWS - 1;
    localparam int DW     = prc_pkg::DATA_W;
    localparam int VW     = prc_pkg::DEV_W;
    localparam int SW     = prc_pkg::SD_W;
    localparam int PW     = prc_pkg::PROD_W;
    localparam int AW     = prc_pkg::ACC_W;
    localparam int PRW    = prc_pkg::ROW_PORT_W;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_SUM  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MAX  = 6'b001000,
        S_PAIR = 6'b010000,
        S_CORR = 6'b100000
    } t_state;

    // configuration and load position
    logic [prc_pkg::CFG_ROWS_W-1:0] r_rows;
    logic [prc_pkg::CFG_COLS_W-1:0] r_cols;
    logic [ROW_W-1:0]  r_lrow;
    logic [COL_W-1:0]  r_lcol;

    // sequencer
    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [ROW_W-1:0]  r_a;
    logic [ROW_W-1:0]  r_b;
    prc_pkg::t_token   r_itok;
    logic [COL_W-1:0]  r_icol;
    prc_pkg::t_cell_ctl r_ctl;
    logic              r_cstart;

    // pair datapath
    logic [DW-1:0]     r_xd [XD_N];
    logic              r_v1, r_v2, r_v3;
    logic signed [VW-1:0] r_dx, r_dy;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [PW-1:0] r_pxx, r_pyy, r_pxy;
    logic [AW-1:0]     r_sxx, r_syy;
    logic signed [AW-1:0] r_sxy;

    // results
    logic              r_strobe;
    logic [PRW-1:0]    r_first, r_second;
    logic signed [prc_pkg::COEF_W-1:0] r_coef;
    logic              r_deg;
    logic              r_last;

    logic [RCNT_W-1:0] w_rows;
    logic [N_W-1:0]    w_n;
    logic [ROW_W-1:0]  w_wrow, w_nrow;
    logic [COL_W-1:0]  w_wcol, w_ncol;
    logic              w_accept;
    logic              w_we;
    logic              w_sweep_end;
    logic              w_last_pair;
    logic [ROW_W-1:0]  w_dist;
    logic [prc_pkg::SH_W-1:0] w_s;
    logic              w_v0;
    logic [DW-1:0]     w_x, w_y;
    logic              w_cdone;
    logic signed [prc_pkg::COEF_W-1:0] w_ccoef;
    logic              w_cdeg;

    prc_pkg::t_token   w_tok_in  [MAX_ROWS];
    prc_pkg::t_token   w_tok_out [MAX_ROWS];
    logic [COL_W-1:0]  w_col_in  [MAX_ROWS];
    logic [COL_W-1:0]  w_col_out [MAX_ROWS];
    logic [DW-1:0]     w_data    [MAX_ROWS];
    logic [DW-1:0]     w_mean    [MAX_ROWS];
    logic [prc_pkg::SH_W-1:0] w_shift [MAX_ROWS];

    function automatic logic signed [SW-1:0] shift_dev(input logic signed [VW-1:0] d,
                                                       input logic [prc_pkg::SH_W-1:0] s);
        logic [VW-1:0] m;
        logic [VW-1:0] ms;
        m  = d[VW-1] ? VW'(-d) : VW'(d);
        ms = m >> s;
        return d[VW-1] ? -$signed(ms[SW-1:0]) : $signed(ms[SW-1:0]);
    endfunction

    // rows and columns in use, clamped to the supported range
    always_comb begin
        int r;
        int c;
        r = int'(r_rows);
        c = int'(r_cols);
        if (r < 2) r = 2;
        if (r > MAX_ROWS) r = MAX_ROWS;
        if (c < 2) c = 2;
        if (c > MAX_COLS) c = MAX_COLS;
        w_rows = RCNT_W'(r);
        w_n    = N_W'(c);
    end

    // write position: step past a position outside the current size, then advance
    always_comb begin
        int wr;
        int wc;
        int nr;
        int nc;
        wr = int'(r_lrow);
        wc = int'(r_lcol);
        if (wc >= int'(w_n)) begin
            wc = 0;
            wr = wr + 1;
        end
        if (wr >= int'(w_rows)) wr = 0;
        nr = wr;
        nc = wc + 1;
        if (nc >= int'(w_n)) begin
            nc = 0;
            nr = nr + 1;
            if (nr >= int'(w_rows)) nr = 0;
        end
        w_wrow = ROW_W'(wr);
        w_wcol = COL_W'(wc);
        w_nrow = ROW_W'(nr);
        w_ncol = COL_W'(nc);
    end

    assign o_busy   = (r_state != S_LOAD);
    assign w_accept = i_start && !o_busy;
    assign w_we     = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= prc_pkg::CFG_ROWS_W'(prc_pkg::ROWS_RESET);
            r_cols <= prc_pkg::CFG_COLS_W'(prc_pkg::COLS_RESET);
        end else if (i_cfg_we) begin
            unique case (prc_pkg::t_cfg_idx'(i_cfg_index))
                prc_pkg::CFG_ROWS: r_rows <= i_cfg_data[prc_pkg::CFG_ROWS_W-1:0];
                prc_pkg::CFG_COLS: r_cols <= i_cfg_data;
                default:           r_rows <= r_rows;
            endcase
        end
    end

    // row cell chain: the column token walks one cell per cycle
    assign w_tok_in[0] = r_itok;
    assign w_col_in[0] = r_icol;

    for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign w_tok_in[k] = w_tok_out[k-1];
            assign w_col_in[k] = w_col_out[k-1];
        end
        prc_row_cell #(
            .MAX_COLS (MAX_COLS),
            .ROW_W    (ROW_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok_in[k]),
            .i_col   (w_col_in[k]),
            .o_tok   (w_tok_out[k]),
            .o_col   (w_col_out[k]),
            .o_data  (w_data[k]),
            .i_ctl   (r_ctl),
            .i_n     (w_n),
            .i_we    (w_we),
            .i_wrow  (w_wrow),
            .i_wcol  (w_wcol),
            .i_wdata (i_sample_value),
            .o_mean  (w_mean[k]),
            .o_shift (w_shift[k])
        );
    end

    assign w_sweep_end = (r_cnt == (CNT_W'(w_n) + CNT_W'(DRAIN - 1)));
    assign w_last_pair = (RCNT_W'(r_b) == w_rows - 1'b1) && (RCNT_W'(r_a) == w_rows - 2'd2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_lrow   <= '0;
            r_lcol   <= '0;
            r_itok   <= '{vld: 1'b0, op: prc_pkg::OP_IDLE};
            r_ctl    <= '{clear: 1'b0, div_start: 1'b0};
            r_cstart <= 1'b0;
            r_strobe <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
        end else begin
            r_ctl    <= '{clear: 1'b0, div_start: 1'b0};
            r_cstart <= 1'b0;
            r_strobe <= 1'b0;
            r_itok   <= '{vld: 1'b0, op: prc_pkg::OP_IDLE};
            r_icol   <= r_cnt[COL_W-1:0];
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (i_matrix_last) begin
                            r_lrow      <= '0;
                            r_lcol      <= '0;
                            r_cnt       <= '0;
                            r_ctl.clear <= 1'b1;
                            r_state     <= S_SUM;
                        end else begin
                            r_lrow <= w_nrow;
                            r_lcol <= w_ncol;
                        end
                    end
                end
                S_SUM, S_MAX, S_PAIR: begin
                    r_itok.vld <= (r_cnt < CNT_W'(w_n));
                    priority if (r_state == S_SUM) begin
                        r_itok.op <= prc_pkg::OP_SUM;
                    end else if (r_state == S_MAX) begin
                        r_itok.op <= prc_pkg::OP_MAX;
                    end else begin
                        r_itok.op <= prc_pkg::OP_PAIR;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (w_sweep_end) begin
                        r_cnt <= '0;
                        priority if (r_state == S_SUM) begin
                            r_ctl.div_start <= 1'b1;
                            r_state         <= S_DIV;
                        end else if (r_state == S_MAX) begin
                            r_a     <= '0;
                            r_b     <= ROW_W'(1);
                            r_state <= S_PAIR;
                        end else begin
                            r_cstart <= 1'b1;
                            r_state  <= S_CORR;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SUM_W + 3)) begin
                        r_cnt   <= '0;
                        r_state <= S_MAX;
                    end
                end
                S_CORR: begin
                    if (w_cdone) begin
                        r_strobe <= 1'b1;
                        r_cnt    <= '0;
                        if (w_last_pair) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_PAIR;
                            if (RCNT_W'(r_b) == w_rows - 1'b1) begin
                                r_a <= r_a + 1'b1;
                                r_b <= r_a + ROW_W'(2);
                            end else begin
                                r_b <= r_b + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (w_cdone) begin
            r_first  <= PRW'(r_a);
            r_second <= PRW'(r_b);
            r_coef   <= w_ccoef;
            r_deg    <= w_cdeg;
            r_last   <= w_last_pair;
        end
    end

    // pair datapath: align row a with row b, centre, scale, multiply, accumulate
    assign w_dist = r_b - r_a - 1'b1;
    assign w_x    = r_xd[w_dist];
    assign w_y    = w_data[r_b];
    assign w_v0   = w_tok_out[r_b].vld && (w_tok_out[r_b].op == prc_pkg::OP_PAIR);
    assign w_s    = (w_shift[r_a] > w_shift[r_b]) ? w_shift[r_a] : w_shift[r_b];

    always_ff @(posedge i_clk) begin
        r_xd[0] <= w_data[r_a];
        for (int i = 1; i < XD_N; i++) begin
            r_xd[i] <= r_xd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= $signed({w_x[DW-1], w_x}) - $signed({w_mean[r_a][DW-1], w_mean[r_a]});
        r_dy  <= $signed({w_y[DW-1], w_y}) - $signed({w_mean[r_b][DW-1], w_mean[r_b]});
        r_sx  <= shift_dev(r_dx, w_s);
        r_sy  <= shift_dev(r_dy, w_s);
        r_pxx <= r_sx * r_sx;
        r_pyy <= r_sy * r_sy;
        r_pxy <= r_sx * r_sy;
        if ((r_state == S_PAIR) && (r_cnt == '0)) begin
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (r_v3) begin
            r_sxx <= r_sxx + AW'(r_pxx);
            r_syy <= r_syy + AW'(r_pyy);
            r_sxy <= r_sxy + {{(AW-PW){r_pxy[PW-1]}}, r_pxy};
        end
    end

    prc_corr_unit u_corr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_cstart),
        .i_sxx        (r_sxx),
        .i_syy        (r_syy),
        .i_sxy        (r_sxy),
        .o_done       (w_cdone),
        .o_coef       (w_ccoef),
        .o_degenerate (w_cdeg)
    );

    assign o_strobe      = r_strobe;
    assign o_first_row   = r_first;
    assign o_second_row  = r_second;
    assign o_coefficient = r_coef;
    assign o_degenerate  = r_deg;
    assign o_last_pair   = r_last;

endmodule
